[rtl/arsr_pkg.sv]
// Package with the shared types and constants of the arcade stick report remapper.
`timescale 1ns / 1ps
package arsr_pkg;

  localparam int BUTTON_COUNT = 15;
  localparam int LAYER_COUNT  = 2;
  localparam int SLOT_COUNT   = 7;

  localparam int BUTTON_W = 4;
  localparam int LAYER_W  = 1;
  localparam int SLOT_W   = 3;
  localparam int ROW_W    = LAYER_W + BUTTON_W;
  localparam int ROW_COUNT = 1 << ROW_W;
  localparam int WORD_W   = 16;

  localparam logic [BUTTON_W-1:0] LAST_BUTTON = BUTTON_W'(BUTTON_COUNT - 1);
  localparam logic [SLOT_W-1:0]   LAST_SLOT   = SLOT_W'(SLOT_COUNT - 1);

  // Report identifiers in packet byte 0.
  localparam logic [7:0] RID_DUMMY     = 8'h01;
  localparam logic [7:0] RID_HEARTBEAT = 8'h03;
  localparam logic [7:0] RID_GUIDE     = 8'h07;
  localparam logic [7:0] RID_BUTTONS   = 8'h20;

  // Button positions in the flag word.
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_X     = 4;
  localparam int BTN_Y     = 5;
  localparam int BTN_A     = 6;
  localparam int BTN_B     = 7;
  localparam int BTN_RB    = 8;
  localparam int BTN_RT    = 9;
  localparam int BTN_LB    = 10;
  localparam int BTN_LT    = 11;
  localparam int BTN_VIEW  = 12;
  localparam int BTN_START = 13;
  localparam int BTN_GUIDE = 14;

  // Output slots of a binding row.
  localparam int SLOT_BUTTONS = 0;
  localparam int SLOT_LT      = 1;
  localparam int SLOT_RT      = 2;
  localparam int SLOT_LX      = 3;
  localparam int SLOT_LY      = 4;
  localparam int SLOT_RX      = 5;
  localparam int SLOT_RY      = 6;

  typedef enum logic [2:0] {
    KIND_UNKNOWN   = 3'd0,
    KIND_DUMMY     = 3'd1,
    KIND_HEARTBEAT = 3'd2,
    KIND_GUIDE     = 3'd3,
    KIND_BUTTONS   = 3'd4
  } packet_kind_t;

  typedef enum logic [1:0] {
    GUIDE_NONE   = 2'd0,
    GUIDE_HOLD   = 2'd1,
    GUIDE_TOGGLE = 2'd2,
    GUIDE_UNUSED = 2'd3
  } guide_mode_t;

  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_BIND   = 1'b1
  } command_t;

  typedef enum logic {
    REG_REMAP_ENABLE = 1'b0,
    REG_GUIDE_MODE   = 1'b1
  } reg_index_t;

  typedef logic [SLOT_COUNT-1:0][WORD_W-1:0] bind_row_t;

endpackage

[rtl/arcade_stick_report_remapper_unit.sv]
// Top level of the arcade stick report remapper: packet decode, binding memory and report build.
`timescale 1ns / 1ps
// A binding write item gives no report. A packet item gives one report: the binding memory
// holds one row of seven slot words per layer and button, and its single read port is swept
// over the fifteen buttons of the active layer, one row per cycle, into a registered read and
// an accumulator before the output register is loaded. The input is ready again in the cycle
// after that load, which waits while a previous report is still stalled by the receiver. A
// new item is taken once the report is loaded, even while the last report still waits. The
// memory needs no clearing pass after reset: a valid bit per slot word makes entries never
// written since reset read as zero.
module arcade_stick_report_remapper_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // packet_length, report_id, byte_four, byte_five, byte_twenty_two, bind_layer,
  // bind_button, bind_slot, bind_value (bit 63 zero)
  input  logic [63:0]                     s_tdata,
  // command
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pad_buttons, left_trigger, right_trigger, left_x, left_y, right_x, right_y,
  // active_layer (bits 103:97 zero)
  output logic [103:0]                    m_tdata,
  // packet_kind
  output logic [2:0]                      m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [1:0]                      cfg_data
);
  import arsr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                      state;
  logic                        remap_enable;
  guide_mode_t                 guide_mode;
  logic [BUTTON_COUNT-1:0]     button_flags;
  logic [BUTTON_COUNT-1:0]     button_flags_next;
  logic                        layer_bit;
  logic                        layer_bit_next;
  packet_kind_t                kind;
  packet_kind_t                kind_next;
  logic [BUTTON_W-1:0]         cnt;
  bind_row_t                   acc;
  logic                        rd_pend;
  bind_row_t                   rd_row;
  logic [SLOT_COUNT-1:0]       rd_vmask;
  packet_kind_t                out_kind;
  bind_row_t                   out_acc;
  logic                        out_layer;

  bind_row_t                   mem [ROW_COUNT];
  logic [SLOT_COUNT-1:0]       slot_valid [ROW_COUNT];

  // Input fields.
  logic [6:0]          in_length;
  logic [7:0]          in_report_id;
  logic [7:0]          in_byte_four;
  logic [7:0]          in_byte_five;
  logic [7:0]          in_byte_twenty_two;
  logic                in_bind_layer;
  logic [BUTTON_W-1:0] in_bind_button;
  logic [SLOT_W-1:0]   in_bind_slot;
  logic [WORD_W-1:0]   in_bind_value;

  logic                in_accept;
  logic                pkt_accept;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_row;
  logic [ROW_W-1:0]    rd_addr;
  logic                guide_bit;

  assign in_length          = s_tdata[6:0];
  assign in_report_id       = s_tdata[14:7];
  assign in_byte_four       = s_tdata[22:15];
  assign in_byte_five       = s_tdata[30:23];
  assign in_byte_twenty_two = s_tdata[38:31];
  assign in_bind_layer      = s_tdata[39];
  assign in_bind_button     = s_tdata[43:40];
  assign in_bind_slot       = s_tdata[46:44];
  assign in_bind_value      = s_tdata[62:47];

  assign s_tready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_accept  = s_tvalid && s_tready;
  assign pkt_accept = in_accept && (s_tuser == CMD_PACKET);
  assign wr_en      = in_accept && (s_tuser == CMD_BIND) &&
                      (in_bind_button <= LAST_BUTTON) && (in_bind_slot <= LAST_SLOT);
  assign wr_row     = {in_bind_layer, in_bind_button};
  assign rd_addr    = {layer_bit, cnt};
  assign guide_bit  = in_byte_four[0];

  // Packet decode: new button flags, layer and kind.
  always_comb begin
    button_flags_next = button_flags;
    layer_bit_next    = layer_bit;
    kind_next         = KIND_UNKNOWN;
    if (in_length != 7'd0) begin
      case (in_report_id)
        RID_DUMMY:     kind_next = KIND_DUMMY;
        RID_HEARTBEAT: kind_next = KIND_HEARTBEAT;
        RID_GUIDE: begin
          kind_next = KIND_GUIDE;
          if (!remap_enable) begin
            button_flags_next[BTN_GUIDE] = guide_bit;
          end else begin
            button_flags_next[BTN_GUIDE] = 1'b0;
            case (guide_mode)
              GUIDE_HOLD:   layer_bit_next = guide_bit;
              GUIDE_TOGGLE: layer_bit_next = layer_bit ^ guide_bit;
              default:      layer_bit_next = layer_bit;
            endcase
          end
        end
        RID_BUTTONS: begin
          kind_next = KIND_BUTTONS;
          button_flags_next[BTN_UP]    = in_byte_five[0];
          button_flags_next[BTN_DOWN]  = in_byte_five[1];
          button_flags_next[BTN_LEFT]  = in_byte_five[2];
          button_flags_next[BTN_RIGHT] = in_byte_five[3];
          button_flags_next[BTN_X]     = in_byte_twenty_two[0];
          button_flags_next[BTN_Y]     = in_byte_twenty_two[1];
          button_flags_next[BTN_A]     = in_byte_twenty_two[4];
          button_flags_next[BTN_B]     = in_byte_twenty_two[5];
          button_flags_next[BTN_RB]    = in_byte_twenty_two[2];
          button_flags_next[BTN_RT]    = in_byte_twenty_two[6];
          button_flags_next[BTN_LB]    = in_byte_twenty_two[3];
          button_flags_next[BTN_LT]    = in_byte_twenty_two[7];
          button_flags_next[BTN_VIEW]  = in_byte_four[3];
          button_flags_next[BTN_START] = in_byte_four[2];
        end
        default: kind_next = KIND_UNKNOWN;
      endcase
    end
  end

  // Binding memory: one slot word written per transaction, one row read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][in_bind_slot] <= in_bind_value;
    end
    rd_row <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        slot_valid[i] <= '0;
      end
    end else if (wr_en) begin
      slot_valid[wr_row][in_bind_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      remap_enable <= 1'b0;
      guide_mode   <= GUIDE_NONE;
      button_flags <= '0;
      layer_bit    <= 1'b0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REMAP_ENABLE: remap_enable <= cfg_data[0];
          REG_GUIDE_MODE:   guide_mode   <= guide_mode_t'(cfg_data);
          default:          remap_enable <= remap_enable;
        endcase
      end
      // In ST_DONE a taken report is always replaced by the new one below.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      // A released button contributes nothing, so its row is masked off on read.
      rd_pend  <= (state == ST_SCAN);
      rd_vmask <= slot_valid[rd_addr] & {SLOT_COUNT{button_flags[cnt]}};
      if (rd_pend) begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          acc[s] <= acc[s] | (rd_vmask[s] ? rd_row[s] : '0);
        end
      end
      case (state)
        ST_IDLE: begin
          if (pkt_accept) begin
            button_flags <= button_flags_next;
            layer_bit    <= layer_bit_next;
            kind         <= kind_next;
            cnt          <= '0;
            acc          <= '0;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == LAST_BUTTON) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_kind  <= kind;
            out_acc   <= acc;
            out_layer <= layer_bit;
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {7'd0,
                    out_layer,
                    out_acc[SLOT_RY],
                    out_acc[SLOT_RX],
                    out_acc[SLOT_LY],
                    out_acc[SLOT_LX],
                    out_acc[SLOT_RT][7:0],
                    out_acc[SLOT_LT][7:0],
                    out_acc[SLOT_BUTTONS]};

`ifndef SYNTHESIS
  a_pkt_starts_scan: assert property (@(posedge clk) disable iff (rst)
    pkt_accept |=> (state == ST_SCAN) && (cnt == '0))
    else $error("packet transaction did not start a memory sweep");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (cnt == LAST_BUTTON) |=> (state == ST_DRAIN))
    else $error("memory sweep did not end after the last button");

  a_pend_follows_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == ST_SCAN))
    else $error("read data taken without a read issued");

  a_layer_kept: assert property (@(posedge clk) disable iff (rst)
    pkt_accept && (in_report_id != RID_GUIDE) |=> $stable(layer_bit))
    else $error("layer changed by a packet that is not a guide packet");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> slot_valid[$past(wr_row)][$past(in_bind_slot)])
    else $error("binding write did not mark its slot valid");
`endif

endmodule

[sim/stick_report_watch.sv]
// Watcher that predicts every gamepad report of the remapper and compares it with the output.
`timescale 1ns / 1ps
module stick_report_watch (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [1:0]   cfg_data,
  output int           mismatch_total,
  output int           reports_owed
);
  import arsr_pkg::*;

  // Input word, highest field first.
  typedef struct packed {
    logic        spare;
    logic [15:0] bind_value;
    logic [2:0]  bind_slot;
    logic [3:0]  bind_button;
    logic        bind_layer;
    logic [7:0]  byte_twenty_two;
    logic [7:0]  byte_five;
    logic [7:0]  byte_four;
    logic [7:0]  report_id;
    logic [6:0]  packet_length;
  } stick_item_t;

  typedef struct packed {
    logic [6:0]         spare;
    logic               active_layer;
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic [7:0]         right_trigger;
    logic [7:0]         left_trigger;
    logic [15:0]        pad_buttons;
  } pad_word_t;

  typedef struct packed {
    packet_kind_t kind;
    pad_word_t    word;
  } gamepad_report_t;

  logic                    remap_on;
  guide_mode_t             guide_sel;
  logic [BUTTON_COUNT-1:0] held_buttons;
  logic                    layer_sel;
  bind_row_t               binding_rows [LAYER_COUNT][BUTTON_COUNT];
  gamepad_report_t         owed_reports [$];
  int                      mismatches = 0;

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h got %h", $realtime, what, want, got);
    end
  endtask

  // Applies one packet to the button and layer state and builds its report.
  task automatic derive_report(input stick_item_t it, output gamepad_report_t rep);
    bind_row_t acc;
    logic      g;
    rep = '0;
    acc = '0;
    g = it.byte_four[0];
    rep.kind = KIND_UNKNOWN;
    if (it.packet_length != 0) begin
      case (it.report_id)
        RID_DUMMY:     rep.kind = KIND_DUMMY;
        RID_HEARTBEAT: rep.kind = KIND_HEARTBEAT;
        RID_GUIDE: begin
          rep.kind = KIND_GUIDE;
          if (!remap_on) begin
            held_buttons[BTN_GUIDE] = g;
          end else begin
            // With remapping on the guide button is swallowed and only steers the layer.
            held_buttons[BTN_GUIDE] = 1'b0;
            if (guide_sel == GUIDE_HOLD)
              layer_sel = g;
            else if (guide_sel == GUIDE_TOGGLE && g)
              layer_sel = ~layer_sel;
          end
        end
        RID_BUTTONS: begin
          rep.kind = KIND_BUTTONS;
          held_buttons[BTN_UP]    = it.byte_five[0];
          held_buttons[BTN_DOWN]  = it.byte_five[1];
          held_buttons[BTN_LEFT]  = it.byte_five[2];
          held_buttons[BTN_RIGHT] = it.byte_five[3];
          held_buttons[BTN_X]     = it.byte_twenty_two[0];
          held_buttons[BTN_Y]     = it.byte_twenty_two[1];
          held_buttons[BTN_A]     = it.byte_twenty_two[4];
          held_buttons[BTN_B]     = it.byte_twenty_two[5];
          held_buttons[BTN_RB]    = it.byte_twenty_two[2];
          held_buttons[BTN_RT]    = it.byte_twenty_two[6];
          held_buttons[BTN_LB]    = it.byte_twenty_two[3];
          held_buttons[BTN_LT]    = it.byte_twenty_two[7];
          held_buttons[BTN_VIEW]  = it.byte_four[3];
          held_buttons[BTN_START] = it.byte_four[2];
        end
        default: ;
      endcase
    end
    for (int b = 0; b < BUTTON_COUNT; b++)
      if (held_buttons[b])
        acc |= binding_rows[layer_sel][b];
    rep.word.pad_buttons   = acc[SLOT_BUTTONS];
    rep.word.left_trigger  = acc[SLOT_LT][7:0];
    rep.word.right_trigger = acc[SLOT_RT][7:0];
    rep.word.left_x        = acc[SLOT_LX];
    rep.word.left_y        = acc[SLOT_LY];
    rep.word.right_x       = acc[SLOT_RX];
    rep.word.right_y       = acc[SLOT_RY];
    rep.word.active_layer  = layer_sel;
  endtask

  always @(posedge clk) begin : watch
    stick_item_t     it;
    gamepad_report_t want;
    gamepad_report_t got;
    if (rst) begin
      remap_on = 1'b0;
      guide_sel = GUIDE_NONE;
      held_buttons = '0;
      layer_sel = 1'b0;
      for (int l = 0; l < LAYER_COUNT; l++)
        for (int b = 0; b < BUTTON_COUNT; b++)
          binding_rows[l][b] = '0;
      owed_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (reg_index_t'(cfg_index) == REG_REMAP_ENABLE)
          remap_on = cfg_data[0];
        else
          guide_sel = guide_mode_t'(cfg_data);
      end
      if (m_tvalid && m_tready) begin
        got.kind = packet_kind_t'(m_tuser);
        got.word = m_tdata;
        if (owed_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report with none pending: kind %0d data %h",
                     $realtime, m_tuser, m_tdata);
        end else begin
          want = owed_reports.pop_front();
          note_mismatch("packet_kind", 16'(want.kind), 16'(got.kind));
          note_mismatch("pad_buttons", want.word.pad_buttons, got.word.pad_buttons);
          note_mismatch("left_trigger", 16'(want.word.left_trigger),
                        16'(got.word.left_trigger));
          note_mismatch("right_trigger", 16'(want.word.right_trigger),
                        16'(got.word.right_trigger));
          note_mismatch("left_x", want.word.left_x, got.word.left_x);
          note_mismatch("left_y", want.word.left_y, got.word.left_y);
          note_mismatch("right_x", want.word.right_x, got.word.right_x);
          note_mismatch("right_y", want.word.right_y, got.word.right_y);
          note_mismatch("active_layer", 16'(want.word.active_layer),
                        16'(got.word.active_layer));
          note_mismatch("padding", 16'(want.word.spare), 16'(got.word.spare));
        end
      end
      if (s_tvalid && s_tready) begin
        it = s_tdata;
        if (command_t'(s_tuser) == CMD_BIND) begin
          if (it.bind_button <= LAST_BUTTON && it.bind_slot <= LAST_SLOT)
            binding_rows[it.bind_layer][it.bind_button][it.bind_slot] = it.bind_value;
        end else begin
          derive_report(it, want);
          owed_reports.push_back(want);
        end
      end
    end
    mismatch_total <= mismatches;
    reports_owed <= owed_reports.size();
  end

endmodule

[sim/tb_arcade_stick_report_remapper_unit.sv]
// Testbench top of the arcade stick report remapper: stimulus, output flow control and verdict.
`timescale 1ns / 1ps
module tb_arcade_stick_report_remapper_unit;
  import arsr_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // packet_length, report_id, byte_four, byte_five, byte_twenty_two, bind_layer,
  // bind_button, bind_slot, bind_value (bit 63 zero)
  logic [63:0]  s_tdata = '0;
  // command
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // pad_buttons, left_trigger, right_trigger, left_x, left_y, right_x, right_y,
  // active_layer (bits 103:97 zero)
  logic [103:0] m_tdata;
  // packet_kind
  logic [2:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [1:0]   cfg_data = '0;

  int           mismatch_total;
  int           reports_owed;
  logic         long_hold = 1'b0;
  logic         hold_spent = 1'b0;
  int           hold_count = 0;
  logic         rx_eager = 1'b0;
  logic         sender_eager = 1'b0;

  always #4 clk = ~clk;

  arcade_stick_report_remapper_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  stick_report_watch report_watch (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_total(mismatch_total), .reports_owed(reports_owed)
  );

  // Report sink: random stalls, one long hold-off per flagged phase, eager stretches.
  always @(posedge clk) begin : report_sink
    int r;
    r = $urandom_range(0, 99);
    if (hold_count != 0) begin
      m_tready <= 1'b0;
      hold_count <= hold_count - 1;
    end else if (long_hold && !hold_spent) begin
      m_tready <= 1'b0;
      hold_count <= 400;
      hold_spent <= 1'b1;
    end else begin
      if (!long_hold)
        hold_spent <= 1'b0;
      if (r == 99)
        rx_eager <= ~rx_eager;
      if (r < 2) begin
        m_tready <= 1'b0;
        hold_count <= $urandom_range(20, 80);
      end else begin
        m_tready <= rx_eager || (r < 70);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (sender_eager)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 80)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item and returns after the edge that accepts it.
  task automatic send(input logic [63:0] word, input command_t cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  // Fields that the command does not use are filled at random.
  task automatic send_packet(input logic [6:0] len, input logic [7:0] rid,
                             input logic [7:0] b4, input logic [7:0] b5,
                             input logic [7:0] b22);
    logic [23:0] junk;
    junk = 24'($urandom);
    send({1'b0, junk, b22, b5, b4, rid, len}, CMD_PACKET);
  endtask

  task automatic send_bind(input logic layer, input logic [3:0] btn,
                           input logic [2:0] slot, input logic [15:0] val);
    logic [38:0] junk;
    junk = 39'({$urandom, $urandom});
    send({1'b0, val, slot, btn, layer, junk}, CMD_BIND);
  endtask

  // Mostly packets that reach the button and guide logic; binding words are sparse
  // so that the ORed reports stay readable. Returns whether the item had any effect.
  task automatic send_random(output bit took);
    int          r;
    logic [3:0]  btn;
    logic [2:0]  slot;
    logic [15:0] val;
    logic [6:0]  len;
    logic [7:0]  rid;
    if ($urandom_range(0, 39) == 0)
      sender_eager = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 25) begin
      btn = 4'($urandom_range(0, 15));
      slot = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       val = 16'($urandom);
        3:       val = '0;
        default: val = 16'h1 << $urandom_range(0, 15);
      endcase
      send_bind(1'($urandom_range(0, 1)), btn, slot, val);
      took = (btn <= LAST_BUTTON) && (slot <= LAST_SLOT);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 6)
        len = '0;
      else if (r < 10)
        len = 7'($urandom_range(65, 127));
      else
        len = 7'($urandom_range(1, 64));
      r = $urandom_range(0, 99);
      if (r < 40)
        rid = RID_BUTTONS;
      else if (r < 65)
        rid = RID_GUIDE;
      else if (r < 73)
        rid = RID_DUMMY;
      else if (r < 81)
        rid = RID_HEARTBEAT;
      else
        rid = 8'($urandom_range(0, 255));
      send_packet(len, rid, 8'($urandom), 8'($urandom), 8'($urandom));
      took = 1'b1;
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin : stimulus
    logic        remap_plan [6];
    guide_mode_t mode_plan [6];
    int          counted;
    bit          took;
    remap_plan = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    mode_plan = '{GUIDE_NONE, GUIDE_HOLD, GUIDE_TOGGLE, GUIDE_UNUSED, GUIDE_TOGGLE,
                  GUIDE_HOLD};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      long_hold <= (ph == 1) || (ph == 4);
      // Bit 1 of the enable write is don't-care and is toggled at random.
      write_reg(REG_REMAP_ENABLE, {1'($urandom_range(0, 1)), remap_plan[ph]});
      write_reg(REG_GUIDE_MODE, mode_plan[ph]);
      cfg_valid <= 1'b0;
      if (ph == 0) begin
        send_bind(1'b0, 4'd0, 3'(SLOT_BUTTONS), 16'hFFFF);
        send_bind(1'b1, LAST_BUTTON, LAST_SLOT, 16'h8000);
        send_bind(1'b0, 4'(BTN_GUIDE), 3'(SLOT_RY), 16'h0001);
        send_bind(1'b0, 4'(BTN_START), 3'(SLOT_LX), 16'h8001);
        send_bind(1'b0, 4'(BTN_VIEW), 3'(SLOT_LT), 16'h01FF);
        // Out-of-range button and slot: both writes are dropped.
        send_bind(1'b0, 4'hF, 3'(SLOT_BUTTONS), 16'h1234);
        send_bind(1'b1, 4'd1, 3'h7, 16'h5678);
        // An empty packet leaves the state alone even with a button report id.
        send_packet(7'd0, RID_BUTTONS, 8'hFF, 8'hFF, 8'hFF);
        send_packet(7'd64, RID_BUTTONS, 8'hFF, 8'hFF, 8'hFF);
        send_packet(7'd1, RID_DUMMY, 8'h00, 8'h00, 8'h00);
        send_packet(7'd127, RID_HEARTBEAT, 8'hFF, 8'h00, 8'hFF);
        send_packet(7'd5, 8'hFF, 8'h01, 8'h00, 8'h00);
        send_packet(7'd1, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_packet(7'd3, RID_GUIDE, 8'h01, 8'h00, 8'h00);
        send_packet(7'd3, RID_GUIDE, 8'hFE, 8'hFF, 8'hFF);
        send_packet(7'd20, RID_BUTTONS, 8'h00, 8'h00, 8'h00);
        send_packet(7'd20, RID_BUTTONS, 8'h0C, 8'h0F, 8'h00);
        send_packet(7'd20, RID_BUTTONS, 8'hF3, 8'hF0, 8'hAA);
        send_bind(1'b1, 4'd0, 3'(SLOT_BUTTONS), 16'hFFFF);
        send_packet(7'd20, RID_BUTTONS, 8'h00, 8'h01, 8'h55);
      end
      counted = 0;
      while (counted < 135) begin
        send_random(took);
        if (took)
          counted++;
      end
      s_tvalid <= 1'b0;
      long_hold <= 1'b0;
      @(posedge clk);
      while (reports_owed != 0) @(posedge clk);
      // A trailing binding write may still be in flight with nothing owed.
      repeat (24) @(posedge clk);
    end
    if (mismatch_total == 0)
      $display("[arcade_stick_report_remapper_unit] OK");
    else
      $display("[arcade_stick_report_remapper_unit] ERROR");
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("[arcade_stick_report_remapper_unit] ERROR");
    $finish;
  end

endmodule
